FILE: sv/priority_lock_arbiter_defines.svh
// Assertion macros used by the priority lock arbiter RTL.
// Stand-alone header with no dependencies; priority_lock_arbiter includes it.
`ifndef PRIORITY_LOCK_ARBITER_DEFINES_SVH
`define PRIORITY_LOCK_ARBITER_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define PLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/plb_pkg.sv
// Package for the priority lock arbiter: status and request codes and the
// control word broadcast to the waiting-list cells. No dependencies.
package plb_pkg;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_FREED     = 3'd2,
    ST_HANDED    = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_FULL      = 3'd5,
    ST_BAD_ID    = 3'd6
  } status_e;

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_e;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

FILE: sv/plb_cell.sv
// One slot of the sorted waiting list of the priority lock arbiter.
// Depends on plb_pkg for the control word.
module plb_cell #(
  parameter int ID_WIDTH = 16,
  parameter int CNT_W    = 7,
  parameter int IDX      = 0
) (
  input  logic                clk_i,
  input  plb_pkg::cell_ctrl_t ctrl_i,
  input  logic [ID_WIDTH-1:0] new_id_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [ID_WIDTH-1:0] prev_id_i,
  input  logic                prev_ge_i,
  input  logic [ID_WIDTH-1:0] next_id_i,
  output logic [ID_WIDTH-1:0] id_o,
  output logic                ge_o
);
  import plb_pkg::*;

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic                occ;
  logic                ge;

  // A slot is occupied when it lies below the fill count.
  assign occ = (IdxC < count_i);
  // Entries of equal id stay ahead of the newcomer, which keeps arrival order.
  assign ge  = occ && (id_q >= new_id_i);

  always_comb begin
    id_d = id_q;
    if (ctrl_i.insert) begin
      if (!ge) begin
        id_d = prev_ge_i ? new_id_i : prev_id_i;
      end
    end else if (ctrl_i.pop) begin
      id_d = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;
  assign ge_o = ge;

endmodule

FILE: sv/priority_lock_arbiter.sv
// Priority lock arbiter top level: owner register, fill count, request decode
// and output register over a chain of plb_cell slots. Depends on plb_pkg.
//
//  Channel  Direction  tdata (low bit first)                     tuser
//  s_axis   in         requester_id[15:0]                        req_type
//  m_axis   out        status[2:0] owner_id[18:3] woken_id[34:19] -
//                      waiting_count[41:35], zero to bit 47
//
// Each word is decided in the cycle it is accepted and its result word is
// registered, so one word per cycle is sustained while m_axis_tready keeps up:
// the cell chain shifts by at most one slot per request.
// rst_ni clears the owner, the fill count and the output valid; the slots
// themselves need no clearing since only those below the count are read.
// A stalled result holds s_axis_tready low until m_axis_tready takes it.
`include "priority_lock_arbiter_defines.svh"

module priority_lock_arbiter #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // requester_id[15:0]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, owner_id, woken_id, waiting_count
);
  import plb_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(QUEUE_DEPTH);

  logic [ID_WIDTH-1:0] owner_q, owner_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                m_valid_q;
  logic [47:0]         m_data_q;

  logic [ID_WIDTH-1:0] cell_id [QUEUE_DEPTH];
  logic                cell_ge [QUEUE_DEPTH];

  logic                fire;
  logic [31:0]         in_ext;
  logic [ID_WIDTH-1:0] req_id;
  status_e             status;
  logic [ID_WIDTH-1:0] woken;
  logic                do_insert, do_pop;
  cell_ctrl_t          ctrl;
  logic [31:0]         owner_ext, woken_ext, count_ext;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign in_ext = {16'b0, s_axis_tdata};
  assign req_id = in_ext[ID_WIDTH-1:0];

  always_comb begin
    status    = ST_BAD_ID;
    owner_d   = owner_q;
    count_d   = count_q;
    woken     = '0;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    priority if (req_id == '0) begin
      status = ST_BAD_ID;
    end else if (req_e'(s_axis_tuser) == REQ_ACQUIRE) begin
      priority if (req_id == owner_q) begin
        status = ST_GRANTED;
      end else if (owner_q == '0) begin
        owner_d = req_id;
        status  = ST_GRANTED;
      end else if (count_q == DepthC) begin
        status = ST_FULL;
      end else begin
        do_insert = 1'b1;
        count_d   = count_q + CNT_W'(1);
        status    = ST_QUEUED;
      end
    end else begin
      priority if (req_id != owner_q) begin
        status = ST_NOT_OWNER;
      end else if (count_q == '0) begin
        owner_d = '0;
        status  = ST_FREED;
      end else begin
        do_pop  = 1'b1;
        woken   = cell_id[0];
        owner_d = cell_id[0];
        count_d = count_q - CNT_W'(1);
        status  = ST_HANDED;
      end
    end
  end

  assign ctrl.insert = fire && do_insert;
  assign ctrl.pop    = fire && do_pop;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] prev_id, next_id;
    logic                prev_ge;
    if (i == 0) begin : g_head
      assign prev_id = '0;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev_id = cell_id[i-1];
      assign prev_ge = cell_ge[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_id = '0;
    end else begin : g_link
      assign next_id = cell_id[i+1];
    end

    plb_cell #(
      .ID_WIDTH(ID_WIDTH),
      .CNT_W   (CNT_W),
      .IDX     (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .new_id_i (req_id),
      .count_i  (count_q),
      .prev_id_i(prev_id),
      .prev_ge_i(prev_ge),
      .next_id_i(next_id),
      .id_o     (cell_id[i]),
      .ge_o     (cell_ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q   <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        owner_q <= owner_d;
        count_q <= count_d;
      end
      if (fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign owner_ext = 32'(owner_d);
  assign woken_ext = 32'(woken);
  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_data_q <= {6'b0, count_ext[6:0], woken_ext[15:0], owner_ext[15:0], status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `PLB_ASSERT(a_count_bound, count_q <= DepthC, "waiting count exceeds depth")
  `PLB_ASSERT(a_free_empty, (owner_q == '0) |-> (count_q == '0), "waiters on a free lock")
  `PLB_ASSERT(a_handover, (ctrl.pop) |=> (owner_q == $past(cell_id[0])), "handover lost head")
  `PLB_ASSERT(a_sorted, (count_q >= CNT_W'(2)) |-> (cell_id[0] >= cell_id[1]), "list out of order")
  `PLB_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=> (!m_axis_tvalid), "result valid in reset")

endmodule
